// ===== rtl/core/tea_pkg.sv =====
`timescale 1ns / 1ps

package tea_pkg;

    localparam int unsigned WordW      = 32;
    localparam int unsigned HalfRounds = 64;
    localparam logic [WordW-1:0] TeaDelta = 32'h9E37_79B9;

    // request codes
    localparam logic [2:0] REQ_ECB_ENC = 3'd0;
    localparam logic [2:0] REQ_ECB_DEC = 3'd1;
    localparam logic [2:0] REQ_CBC_ENC = 3'd2;
    localparam logic [2:0] REQ_CBC_DEC = 3'd3;
    localparam logic [2:0] REQ_OFB     = 3'd4;

    // register indexes on the config port
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 64;
    localparam logic [CfgIdxW-1:0] CFG_KEY_A = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_B = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_C = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY_D = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_IV    = 3'd4;

    typedef struct packed {
        logic [2:0]       req_type;
        logic             first_block;
        logic [WordW-1:0] block_left;
        logic [WordW-1:0] block_right;
    } tea_in_t;

    typedef struct packed {
        logic [WordW-1:0] result_left;
        logic [WordW-1:0] result_right;
    } tea_out_t;

    // per-cycle controls for the shared half-round unit
    typedef struct packed {
        logic             decrypt;
        logic [WordW-1:0] key_a;
        logic [WordW-1:0] key_b;
        logic [WordW-1:0] sum;
    } tea_rnd_ctl_t;

endpackage

// ===== rtl/core/tea_round.sv =====
`timescale 1ns / 1ps

// One TEA half-round, forward or inverse.
module tea_round (
    input  tea_pkg::tea_rnd_ctl_t     ctl,
    input  logic [tea_pkg::WordW-1:0] a,
    input  logic [tea_pkg::WordW-1:0] b,
    output logic [tea_pkg::WordW-1:0] a_next,
    output logic [tea_pkg::WordW-1:0] b_next
);

    logic [tea_pkg::WordW-1:0] x;
    logic [tea_pkg::WordW-1:0] f;

    assign x = ctl.decrypt ? a : b;
    assign f = ((x << 4) + ctl.key_a) ^ (x + ctl.sum) ^ ((x >> 5) + ctl.key_b);

    always_comb
    begin
        if (ctl.decrypt)
        begin
            a_next = b - f;
            b_next = a;
        end
        else
        begin
            a_next = b;
            b_next = a + f;
        end
    end

endmodule

// ===== rtl/core/tea_block_cipher_modes.sv =====
`timescale 1ns / 1ps

// TEA block engine, ECB / additive CBC / additive OFB.
//
// Config: write key words and the IV through cfg_wr_en / cfg_index / cfg_data
// while the engine is idle; a write lands at the clock edge, no read-back.
// Input: one word per in_valid/in_ready handshake carries the request type,
// the first-block flag (reloads the chain register from the IV, any mode)
// and the 64-bit data block. Output: one word per accepted input on
// out_valid/out_ready.
// Timing: one half-round per cycle through a single shared round unit, then
// a final step for the chaining add/subtract, which waits for a free output
// register; out_valid is registered from that final step.
// Unused request codes skip the rounds and go straight to the final step.
// One block at a time: in_ready is high only when idle, so a new block is
// taken only once the last one has left its final step.
// A result parked in the output register does not block the next input;
// if the receiver stalls past the next block's end, the engine holds in its
// final step until the output register frees.
// Reset: keys, IV and chain register clear to zero, engine idle, no output.
module tea_block_cipher_modes #(
    parameter int unsigned HALF_ROUNDS = tea_pkg::HalfRounds
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tea_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tea_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tea_pkg::tea_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tea_pkg::tea_out_t             out_data
);

    localparam int unsigned IDX_W = (HALF_ROUNDS > 1) ? $clog2(HALF_ROUNDS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HALF_ROUNDS - 1);
    // running sum at the last half-round, starting point for decryption
    localparam logic [63:0] SUM_TOP_W =
        64'(tea_pkg::TeaDelta) * 64'((HALF_ROUNDS + 1) / 2);
    localparam logic [tea_pkg::WordW-1:0] SUM_TOP = SUM_TOP_W[tea_pkg::WordW-1:0];

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;

    // config registers
    logic [tea_pkg::WordW-1:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic [63:0]               iv_reg;

    // engine state
    logic [1:0]                state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [tea_pkg::WordW-1:0] sum_reg, sum_next;
    logic [2:0]                mode_reg, mode_next;
    logic                      dec_reg, dec_next;
    logic [tea_pkg::WordW-1:0] a_reg, a_next, b_reg, b_next;
    logic [63:0]               blk_reg, blk_next;
    logic [63:0]               chain_reg, chain_next;
    logic                      out_valid_reg, out_valid_next;
    tea_pkg::tea_out_t         out_reg, out_next;

    // round unit
    tea_pkg::tea_rnd_ctl_t     rnd_ctl;
    logic [tea_pkg::WordW-1:0] rnd_a, rnd_b;

    logic                      accept, out_free, last_round;
    logic                      in_dec;
    logic [63:0]               chain_eff;
    logic [tea_pkg::WordW-1:0] cl, cr;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_round = dec_reg ? (idx_reg == '0) : (idx_reg == IDX_LAST);

    // first-block flag reloads the chain ahead of this block
    assign chain_eff = in_data.first_block ? iv_reg : chain_reg;
    assign cl = chain_eff[63:32];
    assign cr = chain_eff[31:0];
    assign in_dec = in_data.req_type inside {tea_pkg::REQ_ECB_DEC, tea_pkg::REQ_CBC_DEC};

    // odd half-rounds take key words c/d
    assign rnd_ctl.decrypt = dec_reg;
    assign rnd_ctl.key_a   = idx_reg[0] ? key_c_reg : key_a_reg;
    assign rnd_ctl.key_b   = idx_reg[0] ? key_d_reg : key_b_reg;
    assign rnd_ctl.sum     = sum_reg;

    tea_round u_round (
        .ctl    (rnd_ctl),
        .a      (a_reg),
        .b      (b_reg),
        .a_next (rnd_a),
        .b_next (rnd_b)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        mode_next      = mode_reg;
        dec_next       = dec_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        blk_next       = blk_reg;
        chain_next     = chain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_data.req_type;
                    dec_next   = in_dec;
                    blk_next   = {in_data.block_left, in_data.block_right};
                    chain_next = chain_eff;
                    idx_next   = in_dec ? IDX_LAST : '0;
                    sum_next   = in_dec ? SUM_TOP : tea_pkg::TeaDelta;
                    state_next = ST_RUN;
                    case (in_data.req_type)
                        tea_pkg::REQ_CBC_ENC:
                        begin
                            a_next = in_data.block_left + cl;
                            b_next = in_data.block_right + cr;
                        end
                        tea_pkg::REQ_OFB:
                        begin
                            a_next = cl;
                            b_next = cr;
                        end
                        default:
                        begin
                            a_next = in_data.block_left;
                            b_next = in_data.block_right;
                        end
                    endcase
                    // unused codes pass the block through
                    if (in_data.req_type inside {[3'd5:3'd7]})
                    begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_RUN:
            begin
                a_next = rnd_a;
                b_next = rnd_b;
                if (dec_reg)
                begin
                    idx_next = idx_reg - 1'b1;
                    if (!idx_reg[0])
                    begin
                        sum_next = sum_reg - tea_pkg::TeaDelta;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg[0])
                    begin
                        sum_next = sum_reg + tea_pkg::TeaDelta;
                    end
                end
                if (last_round)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    out_next.result_left  = a_reg;
                    out_next.result_right = b_reg;
                    case (mode_reg)
                        tea_pkg::REQ_CBC_ENC:
                        begin
                            chain_next = {a_reg, b_reg};
                        end
                        tea_pkg::REQ_CBC_DEC:
                        begin
                            out_next.result_left  = a_reg - chain_reg[63:32];
                            out_next.result_right = b_reg - chain_reg[31:0];
                            chain_next = blk_reg;
                        end
                        tea_pkg::REQ_OFB:
                        begin
                            chain_next = {a_reg, b_reg};
                            out_next.result_left  = blk_reg[63:32] + a_reg;
                            out_next.result_right = blk_reg[31:0] + b_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
            key_a_reg     <= '0;
            key_b_reg     <= '0;
            key_c_reg     <= '0;
            key_d_reg     <= '0;
            iv_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tea_pkg::CFG_KEY_A: key_a_reg <= cfg_data[tea_pkg::WordW-1:0];
                    tea_pkg::CFG_KEY_B: key_b_reg <= cfg_data[tea_pkg::WordW-1:0];
                    tea_pkg::CFG_KEY_C: key_c_reg <= cfg_data[tea_pkg::WordW-1:0];
                    tea_pkg::CFG_KEY_D: key_d_reg <= cfg_data[tea_pkg::WordW-1:0];
                    tea_pkg::CFG_IV:    iv_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        mode_reg <= mode_next;
        dec_reg  <= dec_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        blk_reg  <= blk_next;
        out_reg  <= out_next;
    end

    // an accepted word always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("engine idle after accepting a word");

    // rounds keep going until the last index
    a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !last_round) |=> state_reg == ST_RUN)
        else $error("round sequence cut short");

    // final step with a free output slot publishes a result and goes idle
    a_post_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not published from final step");

    // a new result only ever comes from the final step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_POST)
        else $error("output raised outside final step");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Top-level bench for tea_block_cipher_modes.
// Flow: reset -> directed table under reset keys -> same table under all-ones
// keys/IV -> six random phases, each with its own key/IV setting.
// Every accepted input word runs through the local TEA predictor below, and
// its result (or a directed row's known result) is queued. Each accepted
// output word is checked against the head of that queue.
module tb;

    localparam int unsigned NumRounds  = tea_pkg::HalfRounds;
    // Cycles with no handshake on either side before giving up. The worst
    // quiet stretch is a long sender gap plus a long receiver stall plus one
    // block, so this leaves a wide margin.
    localparam int unsigned StallLimit = 4000;
    // Settle time after the last result: one full block plus slack.
    localparam int unsigned DrainWait  = NumRounds + 8;
    localparam int unsigned PhaseWords = 60;

    // Request codes the engine does not define; these pass the block through.
    localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI  = 3'd7;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [tea_pkg::CfgIdxW-1:0]  cfg_index;
    logic [tea_pkg::CfgDataW-1:0] cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    tea_pkg::tea_in_t             in_data;
    logic                         out_valid;
    logic                         out_ready;
    tea_pkg::tea_out_t            out_data;

    tea_block_cipher_modes uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Predictor's own copy of the key/IV registers and the chain register.
    logic [tea_pkg::WordW-1:0] key_word [4] = '{default: '0};
    logic [63:0]               iv_word      = '0;
    logic [63:0]               chain_word   = '0;

    tea_pkg::tea_out_t pending_results [$];
    int unsigned       error_count = 0;

    // Directed table. has_known marks rows whose result is obvious
    // (pass-through on spare codes); all other rows use the predictor.
    typedef struct packed {
        logic              has_known;
        tea_pkg::tea_in_t  word;
        tea_pkg::tea_out_t known_out;
    } directed_row_t;

    directed_row_t directed_rows [20] = '{
        // ECB both ways at the data extremes
        '{1'b0, '{tea_pkg::REQ_ECB_ENC, 1'b0, 32'h0000_0000, 32'h0000_0000}, '0},
        '{1'b0, '{tea_pkg::REQ_ECB_DEC, 1'b0, 32'h0000_0000, 32'h0000_0000}, '0},
        '{1'b0, '{tea_pkg::REQ_ECB_ENC, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '0},
        '{1'b0, '{tea_pkg::REQ_ECB_DEC, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '0},
        '{1'b0, '{tea_pkg::REQ_ECB_ENC, 1'b0, 32'h8000_0000, 32'h0000_0001}, '0},
        // chained modes off the prior chain (zero on pass one), no first flag
        '{1'b0, '{tea_pkg::REQ_CBC_ENC, 1'b0, 32'h0000_0000, 32'h0000_0000}, '0},
        '{1'b0, '{tea_pkg::REQ_OFB,     1'b0, 32'h0000_0000, 32'h0000_0000}, '0},
        // spare codes: data passes through; first flag still reloads chain
        '{1'b1, '{REQ_SPARE_LO,  1'b0, 32'h1234_5678, 32'h9ABC_DEF0},
              '{32'h1234_5678, 32'h9ABC_DEF0}},
        '{1'b1, '{REQ_SPARE_MID, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000},
              '{32'hFFFF_FFFF, 32'h0000_0000}},
        '{1'b0, '{tea_pkg::REQ_OFB,     1'b0, 32'h0123_4567, 32'h89AB_CDEF}, '0},
        // CBC encrypt chain: carry out of each word add
        '{1'b0, '{tea_pkg::REQ_CBC_ENC, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '0},
        '{1'b0, '{tea_pkg::REQ_CBC_ENC, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '0},
        // CBC decrypt chain: borrow in each word subtract
        '{1'b0, '{tea_pkg::REQ_CBC_DEC, 1'b1, 32'h0000_0000, 32'h0000_0000}, '0},
        '{1'b0, '{tea_pkg::REQ_CBC_DEC, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '0},
        '{1'b0, '{tea_pkg::REQ_CBC_DEC, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000}, '0},
        // first flag on ECB reloads chain, OFB then runs from the IV
        '{1'b0, '{tea_pkg::REQ_ECB_ENC, 1'b1, 32'hDEAD_BEEF, 32'h0123_4567}, '0},
        '{1'b0, '{tea_pkg::REQ_OFB,     1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '0},
        '{1'b1, '{REQ_SPARE_HI,  1'b0, 32'h0000_0000, 32'hFFFF_FFFF},
              '{32'h0000_0000, 32'hFFFF_FFFF}},
        '{1'b0, '{tea_pkg::REQ_ECB_DEC, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA}, '0},
        '{1'b0, '{tea_pkg::REQ_OFB,     1'b1, 32'h0000_0000, 32'h0000_0000}, '0}
    };

    // ---------------------------------------------------------------
    // TEA predictor
    // ---------------------------------------------------------------

    // Round function for half-round idx; key pair alternates by parity,
    // and the delta multiple steps up every second half-round.
    function automatic logic [tea_pkg::WordW-1:0] tea_mix(
        input logic [tea_pkg::WordW-1:0] x,
        input int unsigned idx);
        logic [tea_pkg::WordW-1:0] ka;
        logic [tea_pkg::WordW-1:0] kb;
        logic [tea_pkg::WordW-1:0] step;
        logic [tea_pkg::WordW-1:0] sum;
        ka   = (idx % 2 == 1) ? key_word[2] : key_word[0];
        kb   = (idx % 2 == 1) ? key_word[3] : key_word[1];
        step = tea_pkg::WordW'((idx + 2) / 2);
        sum  = tea_pkg::TeaDelta * step;
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

    function automatic logic [63:0] tea_encipher(input logic [63:0] blk);
        logic [tea_pkg::WordW-1:0] a;
        logic [tea_pkg::WordW-1:0] b;
        logic [tea_pkg::WordW-1:0] nb;
        a = blk[63:32];
        b = blk[31:0];
        for (int unsigned i = 0; i < NumRounds; i++)
        begin
            nb = a + tea_mix(b, i);
            a  = b;
            b  = nb;
        end
        return {a, b};
    endfunction

    function automatic logic [63:0] tea_decipher(input logic [63:0] blk);
        logic [tea_pkg::WordW-1:0] a;
        logic [tea_pkg::WordW-1:0] b;
        logic [tea_pkg::WordW-1:0] na;
        a = blk[63:32];
        b = blk[31:0];
        for (int unsigned i = NumRounds; i > 0; i--)
        begin
            na = b - tea_mix(a, i - 1);
            b  = a;
            a  = na;
        end
        return {a, b};
    endfunction

    // per-word mod 2^32 add, no carry across the halves
    function automatic logic [63:0] add_words(input logic [63:0] x, input logic [63:0] y);
        return {x[63:32] + y[63:32], x[31:0] + y[31:0]};
    endfunction

    // Result of one input word; advances the chain register like the engine.
    function automatic tea_pkg::tea_out_t tea_mode_result(input tea_pkg::tea_in_t w);
        logic [63:0] blk;
        logic [63:0] res;
        logic [63:0] plain;
        if (w.first_block)
            chain_word = iv_word;
        blk = {w.block_left, w.block_right};
        res = blk;
        case (w.req_type)
            tea_pkg::REQ_ECB_ENC: res = tea_encipher(blk);
            tea_pkg::REQ_ECB_DEC: res = tea_decipher(blk);
            tea_pkg::REQ_CBC_ENC:
            begin
                res        = tea_encipher(add_words(blk, chain_word));
                chain_word = res;
            end
            tea_pkg::REQ_CBC_DEC:
            begin
                plain      = tea_decipher(blk);
                res        = {plain[63:32] - chain_word[63:32],
                              plain[31:0] - chain_word[31:0]};
                chain_word = blk;
            end
            tea_pkg::REQ_OFB:
            begin
                chain_word = tea_encipher(chain_word);
                res        = add_words(blk, chain_word);
            end
            default: res = blk;
        endcase
        return tea_pkg::tea_out_t'(res);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Sender gap: mostly none, some short, a few long.
    function automatic int unsigned pick_gap(input bit back_to_back);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (back_to_back || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Data word with a bias toward the edges of the range.
    function automatic logic [tea_pkg::WordW-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Called right after clk rises; returns right after clk rises with the word
    // accepted. Valid stays up through gap-free streams.
    task automatic send_block(input tea_pkg::tea_in_t w, input int unsigned gap,
                              output tea_pkg::tea_out_t predicted);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = tea_mode_result(w);
    endtask

    // Stop sending and wait until every queued result is back and the
    // engine will take a new word.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0 || !in_ready);
    endtask

    task automatic write_reg(input logic [tea_pkg::CfgIdxW-1:0] idx,
                             input logic [tea_pkg::CfgDataW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            tea_pkg::CFG_KEY_A: key_word[0] = data[31:0];
            tea_pkg::CFG_KEY_B: key_word[1] = data[31:0];
            tea_pkg::CFG_KEY_C: key_word[2] = data[31:0];
            tea_pkg::CFG_KEY_D: key_word[3] = data[31:0];
            tea_pkg::CFG_IV:    iv_word     = data;
            default: ;
        endcase
    endtask

    // Upper bits of a key write are junk; only the low word should land.
    task automatic load_config(input logic [31:0] ka, input logic [31:0] kb,
                               input logic [31:0] kc, input logic [31:0] kd,
                               input logic [63:0] iv);
        write_reg(tea_pkg::CFG_KEY_A, {32'($urandom), ka});
        write_reg(tea_pkg::CFG_KEY_B, {32'($urandom), kb});
        write_reg(tea_pkg::CFG_KEY_C, {32'($urandom), kc});
        write_reg(tea_pkg::CFG_KEY_D, {32'($urandom), kd});
        write_reg(tea_pkg::CFG_IV, iv);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        tea_pkg::tea_out_t predicted;
        foreach (directed_rows[i])
        begin
            send_block(directed_rows[i].word, pick_gap(1'b0), predicted);
            pending_results.push_back(directed_rows[i].has_known ?
                                      directed_rows[i].known_out : predicted);
        end
    endtask

    // Mostly chains: first word carries the first flag, the rest ride the
    // chain. The rest is noise: any code, any flag, single words, plus a few
    // chains with the flag missing or set mid-stream.
    task automatic run_random(input int unsigned count, input bit mid_drain);
        tea_pkg::tea_in_t  w;
        tea_pkg::tea_out_t predicted;
        int unsigned       sent;
        int unsigned       len;
        bit                back_to_back;
        bit                drained;
        bit                noise;
        logic [2:0]        mode;
        sent    = 0;
        drained = 1'b0;
        while (sent < count)
        begin
            // sender holds off until the pipe is empty, then resumes
            if (mid_drain && !drained && sent >= count / 2)
            begin
                wait_idle();
                drained = 1'b1;
            end
            back_to_back = ($urandom_range(0, 3) == 0);
            noise        = ($urandom_range(0, 4) == 0);
            if (noise)
            begin
                mode = 3'($urandom_range(0, 7));
                len  = 1;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       mode = tea_pkg::REQ_ECB_ENC;
                    1:       mode = tea_pkg::REQ_ECB_DEC;
                    2:       mode = tea_pkg::REQ_CBC_ENC;
                    3:       mode = tea_pkg::REQ_CBC_DEC;
                    default: mode = tea_pkg::REQ_OFB;
                endcase
                len = $urandom_range(1, 8);
            end
            for (int unsigned k = 0; k < len; k++)
            begin
                w.req_type    = mode;
                if (noise)
                    w.first_block = 1'($urandom_range(0, 1));
                else if (k == 0)
                    w.first_block = ($urandom_range(0, 7) != 0);
                else
                    w.first_block = ($urandom_range(0, 15) == 0);
                w.block_left  = rand_word();
                w.block_right = rand_word();
                send_block(w, pick_gap(back_to_back), predicted);
                pending_results.push_back(predicted);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Clock, receiver, checker, watchdog
    // ---------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: ready runs in held stretches; short stalls are common,
    // long ones rare, and some long stretches never stall.
    initial
    begin : ready_gen
        int unsigned hold;
        int unsigned r;
        logic        level;
        hold      = 0;
        level     = 1'b1;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    level = 1'b1;
                    hold  = $urandom_range(1, 12);
                end
                else if (r < 85)
                begin
                    level = 1'b0;
                    hold  = $urandom_range(1, 3);
                end
                else if (r < 95)
                begin
                    level = 1'b0;
                    hold  = $urandom_range(4, 20);
                end
                else if (r < 97)
                begin
                    level = 1'b0;
                    hold  = $urandom_range(40, 150);
                end
                else
                begin
                    level = 1'b1;
                    hold  = $urandom_range(100, 300);
                end
            end
            else
                hold--;
            out_ready <= level;
        end
    end

    // Each output word is matched against the oldest queued result.
    always @(posedge clk)
    begin : result_check
        tea_pkg::tea_out_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing queued, got %h %h",
                         $time, out_data.result_left, out_data.result_right);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.result_left !== want.result_left)
                begin
                    $display("%0t: result_left expected %h got %h",
                             $time, want.result_left, out_data.result_left);
                    error_count++;
                end
                if (out_data.result_right !== want.result_right)
                begin
                    $display("%0t: result_right expected %h got %h",
                             $time, want.result_right, out_data.result_right);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, StallLimit, pending_results.size());
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset keys and IV, then at the top extreme.
        run_directed();
        wait_idle();
        load_config('1, '1, '1, '1, '1);
        run_directed();

        // Random phases; config only changes with the pipe empty.
        for (int unsigned phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0:       load_config('0, '0, '0, '0, {$urandom, $urandom});
                1:       load_config(32'h0000_0000, 32'hFFFF_FFFF,
                                     32'h8000_0000, 32'h7FFF_FFFF, '0);
                default: load_config($urandom, $urandom, $urandom, $urandom,
                                     {$urandom, $urandom});
            endcase
            run_random(PhaseWords, phase == 3);
        end

        wait_idle();
        // catch any stray word after the last expected one
        repeat (DrainWait) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
